// ----- src/fbfl_pkg.sv -----
// Shared constants and types for the fixed-block free-list allocator.
`timescale 1ns / 1ps

package fbfl_pkg;

    // Heap geometry; the block size is a power of two
    localparam int MAX_BLOCKS  = 256;
    localparam int BLOCK_BYTES = 128;

    localparam int ADDR_W  = $clog2(MAX_BLOCKS);      // memory index
    localparam int IDX_W   = $clog2(MAX_BLOCKS + 1);  // index plus null code
    localparam int OFF_W   = $clog2(BLOCK_BYTES);     // byte offset inside a block
    localparam int CNT_W   = 9;                       // block_count register
    localparam int DATA_W  = 32;
    localparam int CFG_IDX_W = 8;

    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(MAX_BLOCKS);

    // Action codes
    typedef enum logic [1:0] {
        ACT_INIT    = 2'd0,
        ACT_REQUEST = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = CFG_IDX_W'(1);

endpackage

// ----- src/fbfl_ram.sv -----
// Single-port-write, single-port-read synchronous RAM holding the free-list links.
`timescale 1ns / 1ps

module fbfl_ram #(
    parameter int DEPTH  = 256,
    parameter int AW     = 8,
    parameter int DW     = 9
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/fixed_block_free_list_allocator_core.sv -----
// Top level of the fixed-block free-list allocator: control, registers and result stage.
`timescale 1ns / 1ps

// Manages a heap of equal-size blocks as a LIFO free list whose links live in a
// registered-read RAM of MAX_BLOCKS entries. One item is worked at a time and
// yields one result beat. A release or an unknown action goes from accept via
// S_PEND to the output register; a request passes S_READ first (the link read
// of the head block), an init the S_INIT sweep, which writes one link per cycle.
// The next item is accepted once the previous result has moved into the output
// register, so a result waiting downstream does not block the next accept. The
// link RAM needs no clearing after reset: the list starts empty and only written
// links are ever followed. Configuration must be written by the user through the
// cfg channel while no item is in flight; the block itself does not enforce this.
module fixed_block_free_list_allocator_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbfl_pkg::DATA_W-1:0]    cfg_data,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // [31:0] block_addr
    input  logic [1:0]                     s_tuser,   // [1:0] action
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [31:0] granted_addr
    output logic [1:0]                     m_tuser    // [1:0] status
);

    import fbfl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_INIT,
        S_PEND
    } state_t;

    state_t             state_reg;
    logic [DATA_W-1:0]  heap_base_reg;
    logic [CNT_W-1:0]   block_count_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   init_idx_reg;
    logic [DATA_W-1:0]  pend_addr_reg;
    status_t            pend_status_reg;
    logic [DATA_W-1:0]  out_addr_reg;
    status_t            out_status_reg;
    logic               out_valid_reg;

    logic [IDX_W-1:0]   eff_count;
    logic               s_fire;
    action_t            in_action;
    logic [DATA_W-1:0]  rel_off;
    logic [DATA_W-1:0]  rel_idx;
    logic               rel_ok;
    logic [DATA_W-1:0]  head_addr;
    logic [IDX_W-1:0]   init_succ;
    logic               init_last;
    logic               out_free;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [IDX_W-1:0]   ram_rdata;

    // Saturate the block count to the heap capacity
    assign eff_count = (32'(block_count_reg) > 32'(MAX_BLOCKS)) ? NULL_IDX
                                                               : IDX_W'(block_count_reg);

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign in_action = action_t'(s_tuser);

    // Release check: aligned offset and index below the block count
    assign rel_off = s_tdata - heap_base_reg;
    assign rel_idx = rel_off >> OFF_W;
    assign rel_ok  = (rel_off[OFF_W-1:0] == '0) && (rel_idx < 32'(eff_count));

    // Byte address of the current head block, modulo 2^32
    assign head_addr = heap_base_reg + (32'(head_reg) << OFF_W);

    // Init sweep: link each block to its successor, the last one to null
    assign init_last = ((init_idx_reg + IDX_W'(1)) >= eff_count);
    assign init_succ = init_last ? NULL_IDX : (init_idx_reg + IDX_W'(1));

    assign out_free = !out_valid_reg || m_tready;

    // Link RAM access
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = init_idx_reg[ADDR_W-1:0];
        ram_wdata = init_succ;
        ram_re    = 1'b0;
        ram_raddr = head_reg[ADDR_W-1:0];
        case (state_reg)
            S_IDLE: begin
                if (s_fire && in_action == ACT_RELEASE && rel_ok) begin
                    ram_we    = 1'b1;
                    ram_waddr = rel_idx[ADDR_W-1:0];
                    ram_wdata = head_reg;
                end
                if (s_fire && in_action == ACT_REQUEST && head_reg != NULL_IDX) begin
                    ram_re = 1'b1;
                end
            end
            S_INIT: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    fbfl_ram #(
        .DEPTH (MAX_BLOCKS),
        .AW    (ADDR_W),
        .DW    (IDX_W)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg   <= '0;
            block_count_reg <= CNT_W'(256);
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_HEAP_BASE) begin
                heap_base_reg <= cfg_data;
            end else if (cfg_index == REG_BLOCK_COUNT) begin
                block_count_reg <= cfg_data[CNT_W-1:0];
            end
        end
    end

    // Control sequencer, free-list head and result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= NULL_IDX;
            init_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // drain the output register unless a new result moves in
            if (out_valid_reg && m_tready && state_reg != S_PEND) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        case (in_action)
                            ACT_INIT: begin
                                pend_addr_reg   <= '0;
                                pend_status_reg <= ST_OK;
                                init_idx_reg    <= '0;
                                if (eff_count == '0) begin
                                    head_reg  <= NULL_IDX;
                                    state_reg <= S_PEND;
                                end else begin
                                    head_reg  <= '0;
                                    state_reg <= S_INIT;
                                end
                            end
                            ACT_REQUEST: begin
                                if (head_reg == NULL_IDX) begin
                                    pend_addr_reg   <= '0;
                                    pend_status_reg <= ST_EMPTY;
                                    state_reg       <= S_PEND;
                                end else begin
                                    pend_addr_reg   <= head_addr;
                                    pend_status_reg <= ST_OK;
                                    state_reg       <= S_READ;
                                end
                            end
                            ACT_RELEASE: begin
                                pend_addr_reg <= '0;
                                state_reg     <= S_PEND;
                                if (rel_ok) begin
                                    head_reg        <= rel_idx[IDX_W-1:0];
                                    pend_status_reg <= ST_OK;
                                end else begin
                                    pend_status_reg <= ST_INVALID;
                                end
                            end
                            default: begin
                                pend_addr_reg   <= '0;
                                pend_status_reg <= ST_OK;
                                state_reg       <= S_PEND;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    // pop: successor becomes the new head, clamped to null
                    head_reg  <= (ram_rdata > NULL_IDX) ? NULL_IDX : ram_rdata;
                    state_reg <= S_PEND;
                end
                S_INIT: begin
                    init_idx_reg <= init_idx_reg + IDX_W'(1);
                    if (init_last) begin
                        state_reg <= S_PEND;
                    end
                end
                S_PEND: begin
                    if (out_free) begin
                        out_addr_reg   <= pend_addr_reg;
                        out_status_reg <= pend_status_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_status_reg;

    // A link read always comes in the cycle after the accept of a request
    a_read_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> $past(s_fire && in_action == ACT_REQUEST))
        else $error("link read without a preceding request");

    // The head never holds a code past null
    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= NULL_IDX)
        else $error("free-list head out of range");

    // A rejected release leaves the list untouched
    a_bad_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_action == ACT_RELEASE && !rel_ok) |=> $stable(head_reg))
        else $error("invalid release changed the free list");

    // Only a successful grant carries a nonzero address
    a_addr_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("address reported with a failing status");

endmodule

// ----- dv/fixed_block_free_list_allocator_core_tb.sv -----
// Self-checking testbench for the fixed-block free-list allocator core.
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_core_tb;
    import fbfl_pkg::*;

    localparam int STALL_LIMIT = 3000;  // cycles with no beat before the run is abandoned
    localparam int DRAIN_WAIT  = 300;   // longest init sweep plus margin
    localparam int PHASES      = 12;

    typedef struct packed {
        logic [DATA_W-1:0] granted_addr;
        status_t           status;
    } grant_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        action_t            act;
        logic [DATA_W-1:0]  value;      // block address, or register data
        logic               typed;      // expected result given in the row
        logic [DATA_W-1:0]  exp_addr;
        status_t            exp_status;
    } dir_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    // Directed sequence; rows without a typed result are checked by the predictor
    localparam int DIR_LEN = 31;
    localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
        // list empty after reset
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_REQUEST, 32'h0000_0000, 1'b1, 32'h0, ST_EMPTY},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_RELEASE, 32'h0000_0080, 1'b1, 32'h0, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_REQUEST, 32'h0000_0000, 1'b1, 32'h80, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_REQUEST, 32'h0000_0000, 1'b1, 32'h0, ST_EMPTY},
        // misaligned, one past the end, far outside
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_RELEASE, 32'h0000_0081, 1'b1, 32'h0, ST_INVALID},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_RELEASE, 32'h0000_8000, 1'b1, 32'h0, ST_INVALID},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_RELEASE, 32'hFFFF_FF80, 1'b1, 32'h0, ST_INVALID},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_NONE,    32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_INIT,    32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_REQUEST, 32'h0000_0000, 1'b1, 32'h0, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_REQUEST, 32'h0000_0000, 1'b1, 32'h80, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_RELEASE, 32'h0000_7F80, 1'b1, 32'h0, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_REQUEST, 32'h0000_0000, 1'b1, 32'h7F80, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_REQUEST, 32'h0000_0000, 1'b1, 32'h100, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_RELEASE, 32'h0000_0000, 1'b1, 32'h0, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_REQUEST, 32'h5555_5555, 1'b1, 32'h0, ST_OK},
        // zero blocks: init leaves the list empty
        '{ROW_CFG,  REG_BLOCK_COUNT, ACT_NONE,    32'h0000_0000, 1'b0, 32'h0, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_INIT,    32'h0000_0000, 1'b1, 32'h0, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_REQUEST, 32'h0000_0000, 1'b1, 32'h0, ST_EMPTY},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_RELEASE, 32'h0000_0000, 1'b1, 32'h0, ST_INVALID},
        // count above the heap size saturates; base near the top wraps
        '{ROW_CFG,  REG_BLOCK_COUNT, ACT_NONE,    32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK},
        '{ROW_CFG,  REG_HEAP_BASE,   ACT_NONE,    32'hFFFF_FF80, 1'b0, 32'h0, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_INIT,    32'h0000_0000, 1'b1, 32'h0, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_RELEASE, 32'h0000_7F00, 1'b1, 32'h0, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_REQUEST, 32'h0000_0000, 1'b1, 32'h7F00, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_REQUEST, 32'h0000_0000, 1'b1, 32'hFFFF_FF80, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_REQUEST, 32'h0000_0000, 1'b1, 32'h0, ST_OK},
        // move the base after init: the list keeps its indices
        '{ROW_CFG,  REG_HEAP_BASE,   ACT_NONE,    32'h0000_1000, 1'b0, 32'h0, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_REQUEST, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_RELEASE, 32'h0000_9000, 1'b1, 32'h0, ST_INVALID},
        '{ROW_ITEM, REG_HEAP_BASE,   ACT_RELEASE, 32'h0000_8F80, 1'b0, 32'h0, ST_OK}
    };

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;
    logic [1:0]           m_tuser;

    // Predictor state
    logic [DATA_W-1:0] pred_base  = '0;
    logic [CNT_W-1:0]  pred_count = CNT_W'(256);
    logic [IDX_W-1:0]  link_mem [MAX_BLOCKS];
    logic [IDX_W-1:0]  head_idx   = NULL_IDX;

    grant_t            due_grants [$];
    logic [DATA_W-1:0] held_blocks [$];
    grant_t            oldest_due;
    int                fail_count  = 0;
    int                idle_cycles = 0;
    int                burst_left  = 0;
    int unsigned       rx_cycle    = 0;
    rx_mode_t          rx_mode     = RX_OPEN;

    fixed_block_free_list_allocator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Blocks in use after saturating the count register
    function automatic int live_blocks();
        return (pred_count > CNT_W'(MAX_BLOCKS)) ? MAX_BLOCKS : int'(pred_count);
    endfunction

    // Apply one action to the predicted free list and return its result
    function automatic grant_t alloc_outcome(action_t act, logic [DATA_W-1:0] addr);
        int                n;
        logic [DATA_W-1:0] off;
        logic [DATA_W-1:0] blk;
        grant_t            res;
        n   = live_blocks();
        res = '{granted_addr: '0, status: ST_OK};
        case (act)
            ACT_INIT: begin
                for (int i = 0; i < n; i++)
                    link_mem[i] = (i + 1 < n) ? IDX_W'(i + 1) : NULL_IDX;
                head_idx = (n > 0) ? '0 : NULL_IDX;
            end
            ACT_REQUEST: begin
                if (head_idx >= NULL_IDX) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.granted_addr = pred_base + DATA_W'(head_idx) * DATA_W'(BLOCK_BYTES);
                    head_idx = link_mem[head_idx[ADDR_W-1:0]];
                    if (head_idx > NULL_IDX) head_idx = NULL_IDX;
                end
            end
            ACT_RELEASE: begin
                off = addr - pred_base;
                blk = off / DATA_W'(BLOCK_BYTES);
                if ((off % DATA_W'(BLOCK_BYTES)) != 0 || blk >= DATA_W'(n)) begin
                    res.status = ST_INVALID;
                end else begin
                    link_mem[blk[ADDR_W-1:0]] = head_idx;
                    head_idx = IDX_W'(blk);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Send one input beat, pacing the sender in bursts, and record what it should yield
    task automatic issue_action(action_t act, logic [DATA_W-1:0] addr, logic typed,
                                logic [DATA_W-1:0] exp_addr, status_t exp_status);
        int     gap;
        grant_t res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        res = alloc_outcome(act, addr);
        if (act == ACT_REQUEST && res.status == ST_OK) held_blocks.push_back(res.granted_addr);
        if (typed) due_grants.push_back('{granted_addr: exp_addr, status: exp_status});
        else       due_grants.push_back(res);
    endtask

    // Write a register once every result is back and the block is idle
    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        s_tvalid <= 1'b0;
        while (due_grants.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_HEAP_BASE) begin
            pred_base = data;
            held_blocks.delete();
        end else if (idx == REG_BLOCK_COUNT) begin
            pred_count = data[CNT_W-1:0];
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Pick a release address: mostly blocks handed out earlier, some broken ones
    function automatic logic [DATA_W-1:0] release_addr();
        int                n;
        int                pick;
        int                slot;
        logic [DATA_W-1:0] blk;
        n    = live_blocks();
        pick = $urandom_range(0, 9);
        blk  = (n > 0) ? DATA_W'($urandom_range(0, n - 1)) : '0;
        if (pick <= 5 && held_blocks.size() > 0) begin
            slot = $urandom_range(0, held_blocks.size() - 1);
            release_addr = held_blocks[slot];
            held_blocks.delete(slot);
        end else if (pick <= 6) begin
            release_addr = pred_base + blk * DATA_W'(BLOCK_BYTES);
        end else if (pick == 7) begin
            release_addr = pred_base + blk * DATA_W'(BLOCK_BYTES)
                         + DATA_W'($urandom_range(1, BLOCK_BYTES - 1));
        end else if (pick == 8) begin
            release_addr = pred_base + DATA_W'(n) * DATA_W'(BLOCK_BYTES);
        end else begin
            release_addr = $urandom;
        end
    endfunction

    // Receiver stalls follow a mode picked at random whenever the low byte of rx_cycle is zero
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle[7:0] == 8'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_tready <= ((rx_cycle % 7) >= 3);
            default:     m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_grants.size() == 0) begin
                $error("result beat with nothing expected: granted_addr %h status %0d",
                       m_tdata, m_tuser);
                fail_count++;
            end else begin
                oldest_due = due_grants.pop_front();
                if (m_tdata !== oldest_due.granted_addr) begin
                    $error("granted_addr: expected %h, actual %h",
                           oldest_due.granted_addr, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== oldest_due.status) begin
                    $error("status: expected %0d, actual %0d", oldest_due.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Abandon the run when no beat moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int                phase_items;
        int                r;
        logic [DATA_W-1:0] base_val;
        logic [DATA_W-1:0] count_val;
        action_t           act;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part
        for (int row = 0; row < DIR_LEN; row++) begin
            if (DIR_ROWS[row].kind == ROW_CFG)
                set_register(DIR_ROWS[row].reg_idx, DIR_ROWS[row].value);
            else
                issue_action(DIR_ROWS[row].act, DIR_ROWS[row].value, DIR_ROWS[row].typed,
                             DIR_ROWS[row].exp_addr, DIR_ROWS[row].exp_status);
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            base_val    = $urandom;
            count_val   = DATA_W'($urandom_range(1, 16));
            phase_items = 180;
            case (ph)
                0: begin base_val = 32'h0000_1000; count_val = 8; end
                1: begin base_val = 32'hFFFF_FF00; count_val = 4; end
                2: count_val = 1;
                3: begin count_val = 0; phase_items = 40; end
                4: count_val = {23'($urandom_range(0, 32'h7F_FFFF)), 9'h1FF};
                5: begin base_val = 32'h0; count_val = 256; end
                6: begin base_val = 32'hFFFF_FFFF; count_val = 300; end
                10, 11: count_val = DATA_W'($urandom_range(1, 300));
                default: ;
            endcase
            set_register(REG_HEAP_BASE, base_val);
            set_register(REG_BLOCK_COUNT, count_val);
            if ($urandom_range(0, 4) != 0)
                issue_action(ACT_INIT, $urandom, 1'b0, '0, ST_OK);

            for (int k = 0; k < phase_items; k++) begin
                // at random, move the base mid-phase without a fresh init
                if (k == phase_items / 2 && $urandom_range(0, 1) == 1)
                    set_register(REG_HEAP_BASE, $urandom);
                r = $urandom_range(0, 99);
                if (r < 2)       act = ACT_INIT;
                else if (r < 5)  act = ACT_NONE;
                else if (r < 48) act = ACT_REQUEST;
                else             act = ACT_RELEASE;
                issue_action(act, (act == ACT_RELEASE) ? release_addr() : $urandom,
                             1'b0, '0, ST_OK);
            end
        end

        // Drain and let any stray beat show up
        s_tvalid <= 1'b0;
        while (due_grants.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
